/* rtl/core/upp_pkg.sv */
// Package for the video payload packetizer: word types, widths and header constants.
// It has no dependencies; the core module imports it.
package upp_pkg;

	localparam int LEN_W = 22;
	localparam int PKT_W = 14;
	localparam int TOT_W = 23;
	localparam int LIM_W = 22;
	localparam int CFG_W = 22;
	localparam int HDR_BYTES = 12;
	localparam int HDR_CNT_W = $clog2(HDR_BYTES);
	localparam int DIV_CNT_W = $clog2(LEN_W);

	localparam logic [PKT_W-1:0] PKT_MIN = PKT_W'(HDR_BYTES + 1);
	localparam logic [PKT_W-1:0] PKT_RESET = PKT_W'(1024);
	localparam logic [LIM_W-1:0] LIM_RESET = LIM_W'(3110400);
	localparam logic [TOT_W-1:0] TOT_MAX = '1;

	localparam logic [7:0] HDR_B0 = 8'h0c;
	localparam logic [7:0] HDR_B1 = 8'h8c;
	localparam logic [7:0] EOF_BIT = 8'h02;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	localparam logic CFG_PACKET_BYTES = 1'b0;
	localparam logic CFG_FRAME_LIMIT = 1'b1;

	typedef struct packed {
		logic kind;
		logic [LEN_W-1:0] frame_length;
		logic [7:0] data_byte;
	} upp_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic end_of_packet;
		logic is_report;
		logic rejected;
		logic [LEN_W-1:0] packet_count;
		logic [TOT_W-1:0] total_bytes;
		logic last;
	} upp_out_t;

endpackage

/* rtl/core/uvc_payload_packetizer_core.sv */
// Video payload packetizer core: frame checks, packet count and header insertion.
// Depends on upp_pkg for the word types, widths and header constants.
//
// A frame-start word that passes the length check gets its packet count from one restoring
// divider that produces one quotient bit per cycle over the 22-bit frame length, followed
// by a rounding step and the report step; a rejected frame goes straight to the report.
// A data byte that opens a packet is sent after the 12 header bytes, one header byte at a
// time; any other data byte is sent on its own, and a stray byte is dropped in the cycle
// it is taken. The block takes no new input word until the results of the current one
// are in the output register, which holds one finished word while the next input word
// is taken.
module uvc_payload_packetizer_core (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  upp_pkg::upp_in_t in_word,
	output logic out_valid,
	input  logic out_stall,
	output upp_pkg::upp_out_t out_word,
	input  logic cfg_wen,
	input  logic cfg_index,
	input  logic [upp_pkg::CFG_W-1:0] cfg_data
);
	import upp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_ROUND,
		S_REPORT,
		S_HDR,
		S_DATA
	} state_t;

	localparam int PROD_W = LEN_W + 4;
	localparam int SUM_W = LEN_W + 5;

	state_t state_q;
	logic [PKT_W-1:0] packet_bytes_q;
	logic [LIM_W-1:0] frame_limit_q;
	logic frame_id_q;
	logic [LEN_W-1:0] bytes_remaining_q;
	logic [PKT_W-1:0] payload_position_q;
	logic in_last_packet_q;
	logic frame_accepted_q;

	logic [LEN_W-1:0] len_q;
	logic [7:0] data_q;
	logic eop_q;
	logic rej_q;
	logic [PKT_W-1:0] divisor_q;
	logic [LEN_W-1:0] quo_q;
	logic [PKT_W-1:0] rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [LEN_W-1:0] packets_q;
	logic [HDR_CNT_W-1:0] hdr_cnt_q;
	logic out_valid_q;
	upp_out_t out_word_q;

	logic in_accept;
	logic out_free;
	logic [PKT_W-1:0] pkt_eff;
	logic [PKT_W-1:0] pay;
	logic too_long;
	logic [PKT_W:0] rsh;
	logic rge;
	logic [PKT_W:0] rdiff;
	logic [PKT_W-1:0] pos_inc;
	logic seg_end;
	logic [PROD_W-1:0] prod12;
	logic [SUM_W-1:0] total_sum;
	logic [TOT_W-1:0] total_sat;
	logic [7:0] hdr_byte;
	upp_out_t blank;

	assign in_accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	assign pkt_eff = (packet_bytes_q < PKT_MIN) ? PKT_MIN : packet_bytes_q;
	assign pay = pkt_eff - PKT_W'(HDR_BYTES);
	assign too_long = ({1'b0, in_word.frame_length} + (LEN_W+1)'(HDR_BYTES))
		> {1'b0, frame_limit_q};

	assign rsh = {rem_q, quo_q[LEN_W-1]};
	assign rge = (rsh >= {1'b0, divisor_q});
	assign rdiff = rsh - {1'b0, divisor_q};

	assign pos_inc = payload_position_q + PKT_W'(1);
	assign seg_end = (pos_inc >= pay) || (bytes_remaining_q == LEN_W'(1));

	assign prod12 = {2'b00, packets_q, 2'b00} + {1'b0, packets_q, 3'b000};
	assign total_sum = {5'b0, len_q} + {1'b0, prod12};
	assign total_sat = (total_sum > {4'b0, TOT_MAX}) ? TOT_MAX : total_sum[TOT_W-1:0];

	always_comb begin
		blank = '0;
		if (hdr_cnt_q == HDR_CNT_W'(0)) begin
			hdr_byte = HDR_B0;
		end else if (hdr_cnt_q == HDR_CNT_W'(1)) begin
			hdr_byte = HDR_B1 | {7'b0, !frame_id_q} | (in_last_packet_q ? EOF_BIT : 8'h00);
		end else begin
			hdr_byte = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			packet_bytes_q <= PKT_RESET;
			frame_limit_q <= LIM_RESET;
			frame_id_q <= 1'b0;
			bytes_remaining_q <= '0;
			payload_position_q <= '0;
			in_last_packet_q <= 1'b0;
			frame_accepted_q <= 1'b0;
			len_q <= '0;
			data_q <= '0;
			eop_q <= 1'b0;
			rej_q <= 1'b0;
			divisor_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
			div_cnt_q <= '0;
			packets_q <= '0;
			hdr_cnt_q <= '0;
			out_valid_q <= 1'b0;
			out_word_q <= '0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					CFG_PACKET_BYTES: packet_bytes_q <= cfg_data[PKT_W-1:0];
					CFG_FRAME_LIMIT: frame_limit_q <= cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept && in_word.kind == KIND_START) begin
						len_q <= in_word.frame_length;
						payload_position_q <= '0;
						in_last_packet_q <= 1'b0;
						if (too_long) begin
							frame_accepted_q <= 1'b0;
							bytes_remaining_q <= '0;
							rej_q <= 1'b1;
							packets_q <= '0;
							state_q <= S_REPORT;
						end else begin
							frame_id_q <= !frame_id_q;
							frame_accepted_q <= 1'b1;
							bytes_remaining_q <= in_word.frame_length;
							rej_q <= 1'b0;
							divisor_q <= pay;
							quo_q <= in_word.frame_length;
							rem_q <= '0;
							div_cnt_q <= '0;
							state_q <= S_DIV;
						end
					end else if (in_accept && frame_accepted_q
						&& bytes_remaining_q != '0) begin
						data_q <= in_word.data_byte;
						eop_q <= seg_end;
						bytes_remaining_q <= bytes_remaining_q - LEN_W'(1);
						payload_position_q <= seg_end ? '0 : pos_inc;
						if (bytes_remaining_q == LEN_W'(1)) begin
							frame_accepted_q <= 1'b0;
						end
						if (payload_position_q == '0) begin
							in_last_packet_q <= (bytes_remaining_q <= {{(LEN_W-PKT_W){1'b0}}, pay});
							hdr_cnt_q <= '0;
							state_q <= S_HDR;
						end else begin
							state_q <= S_DATA;
						end
					end
				end
				S_DIV: begin
					rem_q <= rge ? rdiff[PKT_W-1:0] : rsh[PKT_W-1:0];
					quo_q <= {quo_q[LEN_W-2:0], rge};
					div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					if (div_cnt_q == DIV_CNT_W'(LEN_W - 1)) begin
						state_q <= S_ROUND;
					end
				end
				S_ROUND: begin
					packets_q <= quo_q + {{(LEN_W-1){1'b0}}, (rem_q != '0)};
					state_q <= S_REPORT;
				end
				S_REPORT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_word_q <= blank;
						out_word_q.is_report <= 1'b1;
						out_word_q.rejected <= rej_q;
						out_word_q.packet_count <= packets_q;
						out_word_q.total_bytes <= rej_q ? '0 : total_sat;
						out_word_q.last <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_HDR: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_word_q <= blank;
						out_word_q.out_byte <= hdr_byte;
						hdr_cnt_q <= hdr_cnt_q + HDR_CNT_W'(1);
						if (hdr_cnt_q == HDR_CNT_W'(HDR_BYTES - 1)) begin
							state_q <= S_DATA;
						end
					end
				end
				S_DATA: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_word_q <= blank;
						out_word_q.out_byte <= data_q;
						out_word_q.end_of_packet <= eop_q;
						out_word_q.last <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A packet end is always a stream byte and always closes its input word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.end_of_packet) |-> (!out_word.is_report && out_word.last))
		else $error("end of packet on a report or a header byte");

	// A rejected frame reports no packets and no bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.rejected) |->
		(out_word.is_report && out_word.packet_count == '0 && out_word.total_bytes == '0))
		else $error("rejected report carries counts");

	// The divider runs exactly one step per quotient bit.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && div_cnt_q == DIV_CNT_W'(LEN_W - 1)) |=> (state_q == S_ROUND))
		else $error("divider did not finish after the last quotient bit");

	// Header bytes are only produced while a frame was open.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_accept && in_word.kind == KIND_DATA && !frame_accepted_q)
		|=> (state_q == S_IDLE))
		else $error("stray data byte started the output sequencer");

endmodule
